FILE: hw/rtl/affine_point_transform_core_assert.svh
// Assertion macros shared by the affine point transform RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef AFFINE_POINT_TRANSFORM_CORE_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define APT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("affine_point_transform_core: assertion failed");

// Next-cycle implication, checked out of reset.
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("affine_point_transform_core: assertion failed");

`else

`define APT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/apt_pkg.sv
// Shared types and constants of the affine point transform.
// No dependencies.
package apt_pkg;

  localparam int NUM_ROWS   = 3;
  localparam int NUM_COLS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COEF   = NUM_ROWS * NUM_COLS;
  localparam int COEF_IDX_W = 4;

  // First index that does not address a coefficient.
  localparam logic [COEF_IDX_W-1:0] COEF_IDX_LIMIT = COEF_IDX_W'(NUM_COEF);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                  en;
    logic [COEF_IDX_W-1:0] idx;
  } coef_wr_t;

endpackage

FILE: hw/rtl/apt_stream_if.sv
// Valid/ready channel interfaces for the affine point transform.
// Depends on apt_pkg for the coefficient index width.
interface apt_in_if import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [COEF_IDX_W-1:0]         coef_index;
  logic signed [COORD_WIDTH-1:0] coef_value;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;

  modport source (output valid, command, coef_index, coef_value, x_in, y_in, z_in,
                  input ready);
  modport sink   (input valid, command, coef_index, coef_value, x_in, y_in, z_in,
                  output ready);
endinterface

interface apt_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic signed [COORD_WIDTH-1:0] z_out;
  logic                          saturated;

  modport source (output valid, x_out, y_out, z_out, saturated, input ready);
  modport sink   (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface

FILE: hw/rtl/affine_point_transform_core.sv
// Affine point transform core: 3x4 signed fixed-point matrix applied to 3D points.
// Points pass input, product and result registers; the nine multipliers work in parallel.
// Throughput: one item per cycle unless the sink stalls the output; one product stage.
// Coefficient writes give no result and take effect for every point accepted after them.
// Reset (rst_n low, synchronous): pipeline empties, matrix returns to identity.
// Depends on apt_pkg, apt_in_if/apt_out_if, apt_coef_bank, apt_mul_stage, apt_sum_sat.
`include "affine_point_transform_core_assert.svh"

module affine_point_transform_core import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  apt_in_if.sink    in_ch,
  apt_out_if.source out_ch
);

  localparam int PROD_W = 2*COORD_WIDTH - FRAC_BITS;
  localparam logic signed [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Pipeline advance. All stages move together; the output register is the only
  // place that waits on the sink, and an empty output slot lets the pipe flow.
  logic adv;

  // Stage 0: accepted item.
  logic                          v0_r;
  cmd_t                          cmd0_r;
  logic [COEF_IDX_W-1:0]         idx0_r;
  logic signed [COORD_WIDTH-1:0] val0_r;
  logic signed [COORD_WIDTH-1:0] x0_r;
  logic signed [COORD_WIDTH-1:0] y0_r;
  logic signed [COORD_WIDTH-1:0] z0_r;

  // Stage 1: products are valid (point items only).
  logic v1_r;
  logic v1_nxt;

  // Output register.
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] out_x_r;
  logic signed [COORD_WIDTH-1:0] out_y_r;
  logic signed [COORD_WIDTH-1:0] out_z_r;
  logic                          out_sat_r;

  coef_wr_t                      coef_wr;
  logic signed [COORD_WIDTH-1:0] coef     [NUM_COEF];
  logic signed [PROD_W-1:0]      prod     [NUM_ROWS][NUM_AXES];
  logic signed [COORD_WIDTH-1:0] trans    [NUM_ROWS];
  logic signed [COORD_WIDTH-1:0] row_val  [NUM_ROWS];
  logic                          row_sat  [NUM_ROWS];

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0 register: on advance, capture the accepted item or go empty; hold on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r <= cmd_t'(in_ch.command);
      idx0_r <= in_ch.coef_index;
      val0_r <= in_ch.coef_value;
      x0_r   <= in_ch.x_in;
      y0_r   <= in_ch.y_in;
      z0_r   <= in_ch.z_in;
    end
  end

  // A write commits as it leaves stage 0, in item order with the points around it:
  // the point ahead of it has already taken its coefficients into stage 1.
  assign coef_wr.en  = adv && v0_r && (cmd0_r == CMD_WRITE);
  assign coef_wr.idx = idx0_r;

  apt_coef_bank #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (coef_wr),
    .wr_data_i (val0_r),
    .coef_o    (coef)
  );

  apt_mul_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .en_i    (adv),
    .x_i     (x0_r),
    .y_i     (y0_r),
    .z_i     (z0_r),
    .coef_i  (coef),
    .prod_o  (prod),
    .trans_o (trans)
  );

  // Only point items continue past stage 0.
  assign v1_nxt = v0_r && (cmd0_r == CMD_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
    end
  end

  // One adder and clipper per output coordinate.
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    apt_sum_sat #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_sum (
      .prod_i  (prod[r]),
      .trans_i (trans[r]),
      .value_o (row_val[r]),
      .sat_o   (row_sat[r])
    );
  end

  // Output register: advance when empty or when the sink takes the item, else hold.
  assign out_valid_nxt = adv ? v1_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      out_x_r   <= row_val[0];
      out_y_r   <= row_val[1];
      out_z_r   <= row_val[2];
      out_sat_r <= row_sat[0] || row_sat[1] || row_sat[2];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.x_out     = out_x_r;
  assign out_ch.y_out     = out_y_r;
  assign out_ch.z_out     = out_z_r;
  assign out_ch.saturated = out_sat_r;

  // A result only appears when stage 1 held a point.
  `APT_ASSERT_NEXT(a_out_from_stage1, clk, rst_n, !out_valid_r && !v1_r, !out_valid_r)

  // A point moving out of stage 1 always lands in the output register.
  `APT_ASSERT_NEXT(a_stage1_lands, clk, rst_n, v1_r && adv, out_valid_r)

  // The clip flag always comes with at least one coordinate pinned to a range limit.
  `APT_ASSERT_IMPL(a_sat_pinned, clk, rst_n, out_valid_r && out_sat_r, (out_x_r == MAXC) || (out_x_r == MINC) || (out_y_r == MAXC) || (out_y_r == MINC) || (out_z_r == MAXC) || (out_z_r == MINC))

endmodule

FILE: hw/rtl/apt_coef_bank.sv
// Coefficient register bank of the 3x4 matrix, reset to identity.
// Depends on apt_pkg.
module apt_coef_bank import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  coef_wr_t                      wr_i,
  input  logic signed [COORD_WIDTH-1:0] wr_data_i,
  output logic signed [COORD_WIDTH-1:0] coef_o [NUM_COEF]
);

  localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          coef_r[r*NUM_COLS+c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (wr_i.en && (wr_i.idx < COEF_IDX_LIMIT)) begin
      // drop writes beyond the last coefficient
      coef_r[wr_i.idx] <= wr_data_i;
    end
  end

  assign coef_o = coef_r;

endmodule

FILE: hw/rtl/apt_mul_stage.sv
// Product stage: nine signed products, shifted to Q format, and the translations.
// Depends on apt_pkg.
module apt_mul_stage import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int PROD_W     = 2*COORD_WIDTH - FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  input  logic signed [COORD_WIDTH-1:0] coef_i  [NUM_COEF],
  output logic signed [PROD_W-1:0]      prod_o  [NUM_ROWS][NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] trans_o [NUM_ROWS]
);

  logic signed [COORD_WIDTH-1:0]   pt      [NUM_AXES];
  logic signed [2*COORD_WIDTH-1:0] full    [NUM_ROWS][NUM_AXES];
  logic signed [2*COORD_WIDTH-1:0] shifted [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0]        prod_r  [NUM_ROWS][NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   trans_r [NUM_ROWS];

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  // exact product, then arithmetic shift (rounds toward minus infinity)
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        full[r][c]    = pt[c] * coef_i[r*NUM_COLS+c];
        shifted[r][c] = full[r][c] >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod_r[r][c] <= shifted[r][c][PROD_W-1:0];
        end
        trans_r[r] <= coef_i[r*NUM_COLS+NUM_AXES];
      end
    end
  end

  assign prod_o  = prod_r;
  assign trans_o = trans_r;

endmodule

FILE: hw/rtl/apt_sum_sat.sv
// Row adder: three shifted products plus translation, clipped to coordinate range.
// Depends on apt_pkg.
module apt_sum_sat import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int PROD_W     = 2*COORD_WIDTH - FRAC_BITS
) (
  input  logic signed [PROD_W-1:0]      prod_i [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] trans_i,
  output logic signed [COORD_WIDTH-1:0] value_o,
  output logic                          sat_o
);

  localparam int SUM_W = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

  logic signed [SUM_W-1:0] sum;

  always_comb begin
    sum = SUM_W'(prod_i[0]) + SUM_W'(prod_i[1]) + SUM_W'(prod_i[2]) + SUM_W'(trans_i);
    if (sum > MAXV) begin
      value_o = MAXV[COORD_WIDTH-1:0];
      sat_o   = 1'b1;
    end else if (sum < MINV) begin
      value_o = MINV[COORD_WIDTH-1:0];
      sat_o   = 1'b1;
    end else begin
      value_o = sum[COORD_WIDTH-1:0];
      sat_o   = 1'b0;
    end
  end

endmodule
